### design/multilevel_feedback_scheduler_macros.svh
// ----------------------------------------------------------------------------
// multilevel feedback scheduler assertion macros
// clocked concurrent checks shared by the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

// same-cycle implication, idle during reset
`define MLFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define MLFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// shared codes and fixed field widths of the multilevel feedback scheduler
// ----------------------------------------------------------------------------
package mlfs_pkg;

  // fixed field widths
  localparam int ID_W      = 8;
  localparam int QUANT_W   = 16;
  localparam int ELAPSED_W = 32;
  localparam int STATUS_W  = 3;
  localparam int LEVEL_W   = 2;
  localparam int CFG_IDX_W = 2;

  // quantum values after reset
  localparam logic [QUANT_W-1:0] QUANT_HIGH_RST = 16'd2;
  localparam logic [QUANT_W-1:0] QUANT_MID_RST  = 16'd4;
  localparam logic [QUANT_W-1:0] QUANT_LOW_RST  = 16'd8;

  // command codes
  typedef enum logic {
    CMD_ADMIT    = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANT_HIGH = 2'd0,
    CFG_QUANT_MID  = 2'd1,
    CFG_QUANT_LOW  = 2'd2
  } cfg_idx_t;

  // priority levels
  typedef enum logic [LEVEL_W-1:0] {
    LVL_HIGH = 2'd0,
    LVL_MID  = 2'd1,
    LVL_LOW  = 2'd2
  } level_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_ADMITTED  = 3'd0,
    STS_HIGH_FULL = 3'd1,
    STS_DEMOTED   = 3'd2,
    STS_FINISHED  = 3'd3,
    STS_NONE      = 3'd4,
    STS_OVERFLOW  = 3'd5
  } status_t;

endpackage

### design/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// three-level feedback queue scheduler with round-robin lowest level
// ----------------------------------------------------------------------------
// Usage: a command is taken at a rising edge with start high and busy low.
// in_cmd selects admit (push in_job_id / in_burst_length into the high level)
// or dispatch (run the head job of the first non-empty level for one slice).
// Every command gives exactly one result, shown on the out_ ports for one
// cycle with out_strobe high; the receiver cannot stall, so it must take
// each result in that cycle.
// Sequencing:
//   admit, and dispatch with every level empty: result in the cycle after
//   the transfer, next command may follow in that same cycle
//   dispatch of a job: the head entry is read from the level's ring memory
//   at the transfer, then in the run state the slice is computed and any
//   demoted entry written, with busy high during that state
// Quantum registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce; a quantum of zero acts as one, unknown indexes are ignored.
// Synchronous active-low reset empties all three rings, clears the elapsed
// time and restores quanta 2, 4 and 8; ring contents are not cleared.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_scheduler_macros.svh"

module multilevel_feedback_scheduler
  import mlfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [ID_W-1:0]       in_job_id,
  input  logic [TIME_WIDTH-1:0] in_burst_length,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [QUANT_W-1:0]    cfg_data,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_run_id,
  output logic [LEVEL_W-1:0]    out_run_level,
  output logic [QUANT_W-1:0]    out_slice_length,
  output logic [QUANT_W-1:0]    out_remaining_after,
  output logic [ELAPSED_W-1:0]  out_wait_time,
  output logic [ELAPSED_W-1:0]  out_completion_time,
  output logic [ELAPSED_W-1:0]  out_elapsed_time
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ID_W + 2 * TIME_WIDTH;
  localparam int NLVL = 3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control and status registers
  state_t                 st_r, st_nxt;
  level_t                 lv_r, lv_nxt;
  logic [AW-1:0]          head_r [NLVL];
  logic [AW-1:0]          head_nxt [NLVL];
  logic [AW-1:0]          tail_r [NLVL];
  logic [AW-1:0]          tail_nxt [NLVL];
  logic [CW-1:0]          cnt_r [NLVL];
  logic [CW-1:0]          cnt_nxt [NLVL];
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [QUANT_W-1:0]     qhigh_r, qhigh_nxt;
  logic [QUANT_W-1:0]     qmid_r, qmid_nxt;
  logic [QUANT_W-1:0]     qlow_r, qlow_nxt;

  // result registers
  logic                   strobe_r, strobe_nxt;
  status_t                status_r, status_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;
  logic [QUANT_W-1:0]     slice_r, slice_nxt;
  logic [QUANT_W-1:0]     remain_r, remain_nxt;
  logic [ELAPSED_W-1:0]   wait_r, wait_nxt;
  logic [ELAPSED_W-1:0]   turn_r, turn_nxt;

  // ring ports
  logic                   wr_en [NLVL];
  logic [EW-1:0]          wr_data [NLVL];
  logic [EW-1:0]          rd_data [NLVL];
  logic                   rd_en;

  // datapath
  logic                   accept;
  logic                   any_ready;
  level_t                 lv_sel;
  logic                   admit_ok;
  logic [EW-1:0]          head_ent;
  logic [ID_W-1:0]        job_id;
  logic [TIME_WIDTH-1:0]  job_rem;
  logic [TIME_WIDTH-1:0]  job_len;
  logic [QUANT_W-1:0]     q_raw;
  logic [ELAPSED_W-1:0]   q32;
  logic [ELAPSED_W-1:0]   rem32;
  logic [ELAPSED_W-1:0]   len32;
  logic [ELAPSED_W-1:0]   burst32;
  logic                   fits;
  logic [ELAPSED_W-1:0]   run32;
  logic [ELAPSED_W:0]     sum33;
  logic [ELAPSED_W-1:0]   el_new;
  logic [ELAPSED_W-1:0]   left32;
  logic [ELAPSED_W-1:0]   wait32;
  logic                   tgt_full;
  logic                   demote;
  logic                   push_lvl [NLVL];
  logic                   pop_lvl [NLVL];
  logic [EW-1:0]          demote_ent;

  // check terms
  logic                   run_go;
  logic                   cnt_ok;
  logic                   run_nz;

  assign accept = start && (st_r == ST_IDLE);
  assign busy   = (st_r == ST_RUN);
  assign rd_en  = accept && (in_cmd == CMD_DISPATCH);

  // first non-empty level
  assign any_ready = (cnt_r[0] != '0) || (cnt_r[1] != '0) || (cnt_r[2] != '0);
  always_comb begin
    if (cnt_r[0] != '0) begin
      lv_sel = LVL_HIGH;
    end else if (cnt_r[1] != '0) begin
      lv_sel = LVL_MID;
    end else begin
      lv_sel = LVL_LOW;
    end
  end

  assign admit_ok = accept && (in_cmd == CMD_ADMIT) && (cnt_r[0] != CW'(QUEUE_DEPTH));
  assign burst32  = ELAPSED_W'(in_burst_length);

  // head entry and quantum of the level being run
  always_comb begin
    case (lv_r)
      LVL_HIGH: begin
        head_ent = rd_data[0];
        q_raw    = qhigh_r;
        tgt_full = (cnt_r[1] == CW'(QUEUE_DEPTH));
      end
      LVL_MID: begin
        head_ent = rd_data[1];
        q_raw    = qmid_r;
        tgt_full = (cnt_r[2] == CW'(QUEUE_DEPTH));
      end
      LVL_LOW: begin
        // the pop frees a slot in the same ring, so the requeue always fits
        head_ent = rd_data[2];
        q_raw    = qlow_r;
        tgt_full = 1'b0;
      end
      default: begin
        head_ent = rd_data[2];
        q_raw    = qlow_r;
        tgt_full = 1'b0;
      end
    endcase
  end

  assign job_id  = head_ent[EW-1 -: ID_W];
  assign job_rem = head_ent[2*TIME_WIDTH-1 -: TIME_WIDTH];
  assign job_len = head_ent[TIME_WIDTH-1:0];

  // slice arithmetic
  assign q32    = (q_raw == '0) ? ELAPSED_W'(1) : ELAPSED_W'(q_raw);
  assign rem32  = ELAPSED_W'(job_rem);
  assign len32  = ELAPSED_W'(job_len);
  assign fits   = (rem32 <= q32);
  assign run32  = fits ? rem32 : q32;
  assign sum33  = {1'b0, elapsed_r} + {1'b0, run32};
  assign el_new = sum33[ELAPSED_W] ? '1 : sum33[ELAPSED_W-1:0];
  assign left32 = rem32 - q32;
  assign wait32 = (el_new >= len32) ? (el_new - len32) : '0;

  assign demote     = (st_r == ST_RUN) && !fits;
  assign demote_ent = {job_id, left32[TIME_WIDTH-1:0], job_len};

  // ring pushes and pops per level
  assign push_lvl[0] = admit_ok;
  assign push_lvl[1] = demote && (lv_r == LVL_HIGH) && !tgt_full;
  assign push_lvl[2] = demote && (lv_r != LVL_HIGH) && !tgt_full;
  assign pop_lvl[0]  = (st_r == ST_RUN) && (lv_r == LVL_HIGH);
  assign pop_lvl[1]  = (st_r == ST_RUN) && (lv_r == LVL_MID);
  assign pop_lvl[2]  = (st_r == ST_RUN) && (lv_r == LVL_LOW);

  assign wr_data[0] = {in_job_id, in_burst_length, in_burst_length};
  assign wr_data[1] = demote_ent;
  assign wr_data[2] = demote_ent;

  // pointer and count update
  always_comb begin
    for (int l = 0; l < NLVL; l++) begin
      wr_en[l]    = push_lvl[l];
      head_nxt[l] = head_r[l];
      tail_nxt[l] = tail_r[l];
      cnt_nxt[l]  = cnt_r[l];
      if (pop_lvl[l]) begin
        head_nxt[l] = (head_r[l] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r[l] + 1'b1;
      end
      if (push_lvl[l]) begin
        tail_nxt[l] = (tail_r[l] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[l] + 1'b1;
      end
      if (push_lvl[l] && !pop_lvl[l]) begin
        cnt_nxt[l] = cnt_r[l] + 1'b1;
      end else if (pop_lvl[l] && !push_lvl[l]) begin
        cnt_nxt[l] = cnt_r[l] - 1'b1;
      end
    end
  end

  // quantum register writes
  always_comb begin
    qhigh_nxt = qhigh_r;
    qmid_nxt  = qmid_r;
    qlow_nxt  = qlow_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_QUANT_HIGH: qhigh_nxt = cfg_data;
        CFG_QUANT_MID:  qmid_nxt  = cfg_data;
        CFG_QUANT_LOW:  qlow_nxt  = cfg_data;
        default:        qlow_nxt  = qlow_r;
      endcase
    end
  end

  // sequencing and result
  always_comb begin
    st_nxt      = st_r;
    lv_nxt      = lv_r;
    elapsed_nxt = elapsed_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    id_nxt      = id_r;
    level_nxt   = level_r;
    slice_nxt   = slice_r;
    remain_nxt  = remain_r;
    wait_nxt    = wait_r;
    turn_nxt    = turn_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ADMIT) begin
            strobe_nxt = 1'b1;
            status_nxt = admit_ok ? STS_ADMITTED : STS_HIGH_FULL;
            id_nxt     = in_job_id;
            level_nxt  = LVL_HIGH;
            slice_nxt  = '0;
            remain_nxt = burst32[QUANT_W-1:0];
            wait_nxt   = '0;
            turn_nxt   = '0;
          end else if (!any_ready) begin
            strobe_nxt = 1'b1;
            status_nxt = STS_NONE;
            id_nxt     = '0;
            level_nxt  = '0;
            slice_nxt  = '0;
            remain_nxt = '0;
            wait_nxt   = '0;
            turn_nxt   = '0;
          end else begin
            st_nxt = ST_RUN;
            lv_nxt = lv_sel;
          end
        end
      end
      ST_RUN: begin
        st_nxt      = ST_IDLE;
        strobe_nxt  = 1'b1;
        elapsed_nxt = el_new;
        id_nxt      = job_id;
        level_nxt   = lv_r;
        slice_nxt   = run32[QUANT_W-1:0];
        if (fits) begin
          status_nxt = STS_FINISHED;
          remain_nxt = '0;
          wait_nxt   = wait32;
          turn_nxt   = el_new;
        end else begin
          status_nxt = tgt_full ? STS_OVERFLOW : STS_DEMOTED;
          remain_nxt = left32[QUANT_W-1:0];
          wait_nxt   = '0;
          turn_nxt   = '0;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      lv_r      <= LVL_HIGH;
      elapsed_r <= '0;
      strobe_r  <= 1'b0;
      qhigh_r   <= QUANT_HIGH_RST;
      qmid_r    <= QUANT_MID_RST;
      qlow_r    <= QUANT_LOW_RST;
      for (int l = 0; l < NLVL; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      lv_r      <= lv_nxt;
      elapsed_r <= elapsed_nxt;
      strobe_r  <= strobe_nxt;
      qhigh_r   <= qhigh_nxt;
      qmid_r    <= qmid_nxt;
      qlow_r    <= qlow_nxt;
      for (int l = 0; l < NLVL; l++) begin
        head_r[l] <= head_nxt[l];
        tail_r[l] <= tail_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
    end
    status_r <= status_nxt;
    id_r     <= id_nxt;
    level_r  <= level_nxt;
    slice_r  <= slice_nxt;
    remain_r <= remain_nxt;
    wait_r   <= wait_nxt;
    turn_r   <= turn_nxt;
  end

  // one ring per level
  for (genvar g = 0; g < NLVL; g++) begin : g_ring
    mlfs_ring #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW),
      .AW    (AW)
    ) u_ring (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (tail_r[g]),
      .wr_data (wr_data[g]),
      .rd_en   (rd_en),
      .rd_addr (head_r[g]),
      .rd_data (rd_data[g])
    );
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_run_id          = id_r;
  assign out_run_level       = level_r;
  assign out_slice_length    = slice_r;
  assign out_remaining_after = remain_r;
  assign out_wait_time       = wait_r;
  assign out_completion_time = turn_r;
  assign out_elapsed_time    = elapsed_r;

  // terms used by the checks
  assign run_go = rd_en && any_ready;
  assign cnt_ok = (cnt_r[0] <= CW'(QUEUE_DEPTH)) &&
                  (cnt_r[1] <= CW'(QUEUE_DEPTH)) &&
                  (cnt_r[2] <= CW'(QUEUE_DEPTH));
  assign run_nz = (pop_lvl[0] && (cnt_r[0] != '0)) ||
                  (pop_lvl[1] && (cnt_r[1] != '0)) ||
                  (pop_lvl[2] && (cnt_r[2] != '0));

  // checks
  `MLFS_ASSERT_NXT(a_dispatch_runs, run_go, busy, "dispatch of a ready job did not enter run")
  `MLFS_ASSERT_NXT(a_run_single, busy, !busy && out_strobe, "run phase not closed by one result")
  `MLFS_ASSERT_NXT(a_quick_result, accept && !run_go, out_strobe && !busy, "no quick result")
  `MLFS_ASSERT_IMP(a_count_bound, 1'b1, cnt_ok, "ring count beyond depth")
  `MLFS_ASSERT_IMP(a_pop_nonempty, busy, run_nz, "pop from an empty ring")

endmodule

### design/mlfs_ring.sv
// ----------------------------------------------------------------------------
// mlfs_ring
// job storage of one level: one write port, one registered read port
// ----------------------------------------------------------------------------
module mlfs_ring #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 40,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### test/multilevel_feedback_scheduler_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_check
// watches the command and result channels of the three-level feedback
// scheduler, keeps its own copy of the rings, quanta and elapsed time, and
// compares every result strobe field by field with the oldest prediction
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_check
  import mlfs_pkg::*;
#(
  parameter int RING_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_cmd,
  input  logic [ID_W-1:0]      in_job_id,
  input  logic [QUANT_W-1:0]   in_burst_length,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUANT_W-1:0]   cfg_data,
  input  logic                 out_strobe,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [ID_W-1:0]      out_run_id,
  input  logic [LEVEL_W-1:0]   out_run_level,
  input  logic [QUANT_W-1:0]   out_slice_length,
  input  logic [QUANT_W-1:0]   out_remaining_after,
  input  logic [ELAPSED_W-1:0] out_wait_time,
  input  logic [ELAPSED_W-1:0] out_completion_time,
  input  logic [ELAPSED_W-1:0] out_elapsed_time,
  output int                   fail_count,
  output int                   pending,
  output logic [5:0][31:0]     status_tally
);

  // one queued job: id, time still needed, original length
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [QUANT_W-1:0] remaining;
    logic [QUANT_W-1:0] length;
  } job_rec_t;

  // one scheduler result
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      run_id;
    logic [LEVEL_W-1:0]   run_level;
    logic [QUANT_W-1:0]   slice_length;
    logic [QUANT_W-1:0]   remaining_after;
    logic [ELAPSED_W-1:0] wait_time;
    logic [ELAPSED_W-1:0] completion_time;
    logic [ELAPSED_W-1:0] elapsed_time;
  } sched_res_t;

  job_rec_t             ring_mem [3][RING_DEPTH];
  int                   ring_head [3];
  int                   ring_tail [3];
  int                   ring_cnt [3];
  logic [QUANT_W-1:0]   quanta [3];
  logic [ELAPSED_W-1:0] elapsed_total;
  sched_res_t           results_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    status_tally = '0;
  end

  // push at the tail of a level, refused when that level is full
  function automatic bit ring_push(input int lvl, input job_rec_t job);
    if (ring_cnt[lvl] >= RING_DEPTH) return 1'b0;
    ring_mem[lvl][ring_tail[lvl]] = job;
    ring_tail[lvl] = (ring_tail[lvl] + 1) % RING_DEPTH;
    ring_cnt[lvl]++;
    return 1'b1;
  endfunction

  // saturating advance of the elapsed time
  function automatic void charge(input logic [QUANT_W-1:0] t);
    logic [ELAPSED_W:0] sum;
    sum = {1'b0, elapsed_total} + (ELAPSED_W+1)'(t);
    elapsed_total = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
  endfunction

  // predict the result of one command and update the scheduler state
  task automatic schedule_command(input logic cmd, input logic [ID_W-1:0] id,
                                  input logic [QUANT_W-1:0] len,
                                  output sched_res_t r);
    job_rec_t           job;
    int                 lvl;
    int                 nxt;
    logic [QUANT_W-1:0] q;
    r = '0;
    if (cmd == CMD_ADMIT) begin
      job.id        = id;
      job.length    = len;
      job.remaining = len;
      r.status          = ring_push(LVL_HIGH, job) ? STS_ADMITTED : STS_HIGH_FULL;
      r.run_id          = id;
      r.remaining_after = len;
    end else begin
      lvl = 0;
      while (lvl < 3 && ring_cnt[lvl] == 0) lvl++;
      if (lvl == 3) begin
        r.status = STS_NONE;
      end else begin
        // pop the head of the first non-empty level
        job = ring_mem[lvl][ring_head[lvl]];
        ring_head[lvl] = (ring_head[lvl] + 1) % RING_DEPTH;
        ring_cnt[lvl]--;
        q = (quanta[lvl] == '0) ? QUANT_W'(1) : quanta[lvl];
        r.run_id    = job.id;
        r.run_level = lvl[LEVEL_W-1:0];
        if (job.remaining <= q) begin
          charge(job.remaining);
          r.status          = STS_FINISHED;
          r.slice_length    = job.remaining;
          r.remaining_after = '0;
          r.wait_time       = (elapsed_total >= ELAPSED_W'(job.length)) ?
                              elapsed_total - ELAPSED_W'(job.length) : '0;
          r.completion_time = elapsed_total;
        end else begin
          // one quantum, then one level down; low requeues to itself
          nxt = (lvl < 2) ? lvl + 1 : 2;
          job.remaining = job.remaining - q;
          charge(q);
          r.slice_length    = q;
          r.remaining_after = job.remaining;
          r.status          = ring_push(nxt, job) ? STS_DEMOTED : STS_OVERFLOW;
        end
      end
    end
    r.elapsed_time = elapsed_total;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare results, follow register writes, predict accepted commands
  always @(posedge clk) begin : watch
    sched_res_t want;
    int         k;
    if (!rst_n) begin
      for (k = 0; k < 3; k++) begin
        ring_head[k] = 0;
        ring_tail[k] = 0;
        ring_cnt[k]  = 0;
      end
      quanta[LVL_HIGH] = QUANT_HIGH_RST;
      quanta[LVL_MID]  = QUANT_MID_RST;
      quanta[LVL_LOW]  = QUANT_LOW_RST;
      elapsed_total    = '0;
      results_due.delete();
      pending      = 0;
      status_tally = '0;
    end else begin
      if (out_strobe) begin
        if (results_due.size() == 0) begin
          $error("result strobe with no command outstanding");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("run_id", 32'(want.run_id), 32'(out_run_id));
          check_field("run_level", 32'(want.run_level), 32'(out_run_level));
          check_field("slice_length", 32'(want.slice_length), 32'(out_slice_length));
          check_field("remaining_after", 32'(want.remaining_after),
                      32'(out_remaining_after));
          check_field("wait_time", want.wait_time, out_wait_time);
          check_field("completion_time", want.completion_time, out_completion_time);
          check_field("elapsed_time", want.elapsed_time, out_elapsed_time);
        end
        if (out_status <= STS_OVERFLOW) status_tally[out_status] += 1;
      end
      // writes to unmapped indexes are dropped
      if (cfg_we && cfg_index <= CFG_QUANT_LOW) quanta[cfg_index] = cfg_data;
      if (start && !busy) begin
        schedule_command(in_cmd, in_job_id, in_burst_length, want);
        results_due.push_back(want);
      end
      pending = results_due.size();
    end
  end

endmodule

### test/multilevel_feedback_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_test
// drives admit and dispatch commands into the scheduler: a directed walk
// through every level, a flood that fills the rings to overflow,
// then random command mixes under several quantum settings and sender gaps
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_test;
  import mlfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_cmd;
  logic [ID_W-1:0]      in_job_id;
  logic [QUANT_W-1:0]   in_burst_length;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [QUANT_W-1:0]   cfg_data;
  logic                 out_strobe;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_run_id;
  logic [LEVEL_W-1:0]   out_run_level;
  logic [QUANT_W-1:0]   out_slice_length;
  logic [QUANT_W-1:0]   out_remaining_after;
  logic [ELAPSED_W-1:0] out_wait_time;
  logic [ELAPSED_W-1:0] out_completion_time;
  logic [ELAPSED_W-1:0] out_elapsed_time;

  int               fail_count;
  int               pending;
  logic [5:0][31:0] status_tally;
  logic             took;
  int               gap_pct;
  int               commands_sent;

  multilevel_feedback_scheduler i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_job_id           (in_job_id),
    .in_burst_length     (in_burst_length),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_run_id          (out_run_id),
    .out_run_level       (out_run_level),
    .out_slice_length    (out_slice_length),
    .out_remaining_after (out_remaining_after),
    .out_wait_time       (out_wait_time),
    .out_completion_time (out_completion_time),
    .out_elapsed_time    (out_elapsed_time)
  );

  multilevel_feedback_scheduler_check i_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_job_id           (in_job_id),
    .in_burst_length     (in_burst_length),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_run_id          (out_run_id),
    .out_run_level       (out_run_level),
    .out_slice_length    (out_slice_length),
    .out_remaining_after (out_remaining_after),
    .out_wait_time       (out_wait_time),
    .out_completion_time (out_completion_time),
    .out_elapsed_time    (out_elapsed_time),
    .fail_count          (fail_count),
    .pending             (pending),
    .status_tally        (status_tally)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // command transfer seen at the last rising edge
  always @(posedge clk) took <= rst_n && start && !busy;

  // run limit
  initial begin
    #5_000_000;
    $display("multilevel_feedback_scheduler_test: errors");
    $finish;
  end

  // one command transfer, after a random sender gap
  task automatic send(input cmd_t cmd, input logic [ID_W-1:0] id,
                      input logic [QUANT_W-1:0] len);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_job_id       <= id;
    in_burst_length <= len;
    @(negedge clk);
    while (!took) @(negedge clk);
    commands_sent++;
  endtask

  // drop start and wait until every result is back
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [QUANT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // all three quanta plus a write to the unmapped index
  task automatic program_quanta(input logic [QUANT_W-1:0] qh,
                                input logic [QUANT_W-1:0] qm,
                                input logic [QUANT_W-1:0] ql,
                                input logic [QUANT_W-1:0] junk);
    settle();
    put_reg(CFG_QUANT_HIGH, qh);
    put_reg(CFG_QUANT_MID, qm);
    put_reg(CFG_UNMAPPED, junk);
    put_reg(CFG_QUANT_LOW, ql);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random admits and dispatches, mostly short bursts
  task automatic mix(input int n, input int dispatch_pct);
    int                 k;
    logic [QUANT_W-1:0] len;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 70) len = QUANT_W'($urandom_range(24));
      else len = QUANT_W'($urandom);
      send(($urandom_range(99) < dispatch_pct) ? CMD_DISPATCH : CMD_ADMIT,
           ID_W'($urandom), len);
    end
  endtask

  // fill high until full, push it all into a full mid, then into low
  task automatic flood_levels();
    int k;
    for (k = 0; k < 129; k++) begin
      send(CMD_ADMIT, ID_W'(k), QUANT_W'($urandom_range(65535, 1000)));
    end
    for (k = 0; k < 128; k++) send(CMD_DISPATCH, ID_W'($urandom), QUANT_W'($urandom));
    // high head demoted into a full mid
    send(CMD_ADMIT, 8'hEE, 16'hFFFF);
    send(CMD_DISPATCH, ID_W'($urandom), QUANT_W'($urandom));
    // mid drains into low, then low requeues to itself
    for (k = 0; k < 132; k++) send(CMD_DISPATCH, ID_W'($urandom), QUANT_W'($urandom));
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = CMD_ADMIT;
    in_job_id       = '0;
    in_burst_length = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_QUANT_HIGH;
    cfg_data        = '0;
    gap_pct         = 13;
    commands_sent   = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk with the reset quanta 2, 4, 8
    send(CMD_DISPATCH, 8'hFF, 16'hFFFF);   // nothing ready
    send(CMD_ADMIT, 8'h00, 16'h0000);      // zero-length job
    send(CMD_ADMIT, 8'hFF, 16'hFFFF);      // longest job
    send(CMD_ADMIT, 8'hA5, 16'd2);         // exactly one high quantum
    send(CMD_ADMIT, 8'h5A, 16'd3);
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // zero-length job finishes
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // longest job to mid
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // finishes on the quantum
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // to mid with one left
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // mid to low
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // finishes in mid
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // low requeues to itself
    send(CMD_ADMIT, 8'h0F, 16'd7);
    send(CMD_DISPATCH, 8'h00, 16'h0000);
    send(CMD_DISPATCH, 8'h00, 16'h0000);
    send(CMD_DISPATCH, 8'h00, 16'h0000);
    send(CMD_DISPATCH, 8'h00, 16'h0000);   // finishes in low
    send(CMD_ADMIT, 8'h33, 16'd1);
    send(CMD_DISPATCH, 8'hFF, 16'hFFFF);

    // zero quantum acts as one
    program_quanta(16'd0, 16'd1, 16'd1, 16'hFFFF);
    flood_levels();

    // widest quanta drain low, slow sender
    program_quanta(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    gap_pct = 82;
    mix(80, 65);

    // small random quanta, no sender gaps
    program_quanta(QUANT_W'($urandom_range(6, 1)), QUANT_W'($urandom_range(6, 1)),
                   QUANT_W'($urandom_range(6, 1)), QUANT_W'($urandom));
    gap_pct = 0;
    mix(80, 50);
    program_quanta(16'd1, 16'hFFFF, 16'd3, 16'h5555);
    mix(30, 45);

    settle();
    repeat (4) @(negedge clk);
    $display("covered %0d commands: %0d admitted, %0d high full, %0d demoted,",
             commands_sent, status_tally[STS_ADMITTED], status_tally[STS_HIGH_FULL],
             status_tally[STS_DEMOTED]);
    $display("  %0d finished, %0d with nothing ready, %0d demotion overflows",
             status_tally[STS_FINISHED], status_tally[STS_NONE],
             status_tally[STS_OVERFLOW]);
    if (fail_count == 0) begin
      $display("multilevel_feedback_scheduler_test: clean");
    end else begin
      $display("multilevel_feedback_scheduler_test: errors");
    end
    $finish;
  end

endmodule
